FILE: sv/vha_pkg.sv
`timescale 1ns / 1ps
package vha_pkg;

  // port widths, fixed by the transaction format
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned REQ_W    = 7;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned VER_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIVE_W   = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_STALE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CREATE,
    S_POP,
    S_LOOK
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [VER_W-1:0]    version;
    status_e             status;
    logic                handle_valid;
    logic [LIVE_W-1:0]   live_count;
    logic                last;
  } result_t;

endpackage

FILE: sv/versioned_handle_allocator_unit.sv
`timescale 1ns / 1ps
// destroy, check and unknown: version memory read on acceptance, result registered from S_LOOK
// create: a high-water counter handle is registered from S_CREATE; one popped off the
//   free stack takes a stack read in S_CREATE, then a version write-back in S_POP
// one transaction at a time; a held output register stalls the sequencer until the
//   receiver takes it
// reset: counters and control clear at once, no memory sweep, the version store reads as zero
module versioned_handle_allocator_unit #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned VERSION_BITS = 16,
  parameter int unsigned MAX_BATCH    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vha_pkg::CMD_W-1:0]     command_i,
  input  logic [vha_pkg::REQ_W-1:0]     request_count_i,
  input  logic [vha_pkg::IDX_W-1:0]     slot_index_i,
  input  logic [vha_pkg::VER_W-1:0]     slot_version_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vha_pkg::IDX_W-1:0]     out_index_o,
  output logic [vha_pkg::VER_W-1:0]     out_version_o,
  output logic [vha_pkg::STATUS_W-1:0]  status_o,
  output logic                          handle_valid_o,
  output logic [vha_pkg::LIVE_W-1:0]    live_count_o,
  output logic                          last_o
);

  localparam int unsigned IW = $clog2(MAX_SLOTS);

  // version memory entry: {live, version}
  // entries at or above the high-water mark are never written, the controller
  // masks their read data to zero so no clearing pass is needed
  logic                   vmem_we;
  logic [IW-1:0]          vmem_waddr;
  logic [VERSION_BITS:0]  vmem_wdata;
  logic                   vmem_re;
  logic [IW-1:0]          vmem_raddr;
  logic [VERSION_BITS:0]  vmem_rdata;

  // free stack entry: {slot index, version the slot was freed with}
  // a freed slot's version cannot change while it sits on the stack, so a pop
  // yields the full handle without a second memory lookup
  logic                         smem_we;
  logic [IW-1:0]                smem_waddr;
  logic [IW+VERSION_BITS-1:0]   smem_wdata;
  logic                         smem_re;
  logic [IW-1:0]                smem_raddr;
  logic [IW+VERSION_BITS-1:0]   smem_rdata;

  vha_pkg::result_t out_res;

  vha_ram #(
    .WIDTH (VERSION_BITS + 1),
    .DEPTH (MAX_SLOTS)
  ) u_version_ram (
    .clk_i   (clk_i),
    .we_i    (vmem_we),
    .waddr_i (vmem_waddr),
    .wdata_i (vmem_wdata),
    .re_i    (vmem_re),
    .raddr_i (vmem_raddr),
    .rdata_o (vmem_rdata)
  );

  vha_ram #(
    .WIDTH (IW + VERSION_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (smem_we),
    .waddr_i (smem_waddr),
    .wdata_i (smem_wdata),
    .re_i    (smem_re),
    .raddr_i (smem_raddr),
    .rdata_o (smem_rdata)
  );

  // sequencer: decode, read-modify-write of the version entry, stack push/pop
  vha_ctrl #(
    .MAX_SLOTS    (MAX_SLOTS),
    .VERSION_BITS (VERSION_BITS),
    .MAX_BATCH    (MAX_BATCH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .request_count_i (request_count_i),
    .slot_index_i    (slot_index_i),
    .slot_version_i  (slot_version_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_res_o       (out_res),
    .vmem_we_o       (vmem_we),
    .vmem_waddr_o    (vmem_waddr),
    .vmem_wdata_o    (vmem_wdata),
    .vmem_re_o       (vmem_re),
    .vmem_raddr_o    (vmem_raddr),
    .vmem_rdata_i    (vmem_rdata),
    .smem_we_o       (smem_we),
    .smem_waddr_o    (smem_waddr),
    .smem_wdata_o    (smem_wdata),
    .smem_re_o       (smem_re),
    .smem_raddr_o    (smem_raddr),
    .smem_rdata_i    (smem_rdata)
  );

  // unpack the registered result onto the output ports
  assign out_index_o    = out_res.index;
  assign out_version_o  = out_res.version;
  assign status_o       = out_res.status;
  assign handle_valid_o = out_res.handle_valid;
  assign live_count_o   = out_res.live_count;
  assign last_o         = out_res.last;

endmodule

FILE: sv/vha_ram.sv
`timescale 1ns / 1ps
module vha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/vha_ctrl.sv
`timescale 1ns / 1ps
module vha_ctrl #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned VERSION_BITS = 16,
  parameter int unsigned MAX_BATCH    = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [vha_pkg::CMD_W-1:0]             command_i,
  input  logic [vha_pkg::REQ_W-1:0]             request_count_i,
  input  logic [vha_pkg::IDX_W-1:0]             slot_index_i,
  input  logic [vha_pkg::VER_W-1:0]             slot_version_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output vha_pkg::result_t                      out_res_o,
  output logic                                  vmem_we_o,
  output logic [$clog2(MAX_SLOTS)-1:0]          vmem_waddr_o,
  output logic [VERSION_BITS:0]                 vmem_wdata_o,
  output logic                                  vmem_re_o,
  output logic [$clog2(MAX_SLOTS)-1:0]          vmem_raddr_o,
  input  logic [VERSION_BITS:0]                 vmem_rdata_i,
  output logic                                  smem_we_o,
  output logic [$clog2(MAX_SLOTS)-1:0]          smem_waddr_o,
  output logic [$clog2(MAX_SLOTS)+VERSION_BITS-1:0] smem_wdata_o,
  output logic                                  smem_re_o,
  output logic [$clog2(MAX_SLOTS)-1:0]          smem_raddr_o,
  input  logic [$clog2(MAX_SLOTS)+VERSION_BITS-1:0] smem_rdata_i
);

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned VB = VERSION_BITS;
  localparam int unsigned LW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned RW = $clog2(MAX_BATCH + 1);

  vha_pkg::state_e state_q, state_d;
  logic [LW-1:0] ft_q, ft_d;
  logic [LW-1:0] hw_q, hw_d;
  logic [LW-1:0] live_q, live_d;
  logic          out_valid_q, out_valid_d;
  vha_pkg::result_t out_res_q, out_res_d;

  vha_pkg::cmd_e            cmd_q, cmd_d;
  logic [RW-1:0]            rem_q, rem_d;
  logic [vha_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [vha_pkg::VER_W-1:0] ver_q, ver_d;

  logic          accept;
  logic          can_emit;
  logic          emit;
  logic          have_free;
  logic          have_hw;
  logic          last_one;
  logic          mapped;
  logic          stored_live;
  logic [VB-1:0] stored_ver;
  logic [VB-1:0] new_ver;
  logic          ok;
  logic [IW-1:0] pop_slot;
  logic [VB-1:0] pop_ver;

  assign accept    = (state_q == vha_pkg::S_IDLE) && in_valid_i;
  assign can_emit  = !out_valid_q || !out_stall_i;
  assign have_free = (ft_q != '0);
  assign have_hw   = (32'(hw_q) < 32'(MAX_SLOTS));
  assign last_one  = (rem_q == RW'(1));

  // a slot at or above the high-water mark was never handed out: version 0, not live
  assign mapped      = (32'(idx_q) < 32'(MAX_SLOTS)) && (32'(idx_q) < 32'(hw_q));
  assign stored_live = mapped && vmem_rdata_i[VB];
  assign stored_ver  = mapped ? vmem_rdata_i[VB-1:0] : '0;
  assign ok          = stored_live && (32'(stored_ver) == 32'(ver_q));
  assign new_ver     = stored_ver + VB'(1);

  assign pop_slot = smem_rdata_i[IW+VB-1:VB];
  assign pop_ver  = smem_rdata_i[VB-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vha_pkg::S_IDLE: begin
        if (accept) begin
          if (vha_pkg::cmd_e'(command_i) == vha_pkg::CMD_CREATE) begin
            state_d = (request_count_i == '0) ? vha_pkg::S_IDLE : vha_pkg::S_CREATE;
          end else begin
            state_d = vha_pkg::S_LOOK;
          end
        end
      end
      vha_pkg::S_CREATE: begin
        if (have_free) begin
          state_d = vha_pkg::S_POP;
        end else if (can_emit && (!have_hw || last_one)) begin
          state_d = vha_pkg::S_IDLE;
        end
      end
      vha_pkg::S_POP: begin
        if (can_emit) begin
          state_d = last_one ? vha_pkg::S_IDLE : vha_pkg::S_CREATE;
        end
      end
      vha_pkg::S_LOOK: begin
        if (can_emit) begin
          state_d = vha_pkg::S_IDLE;
        end
      end
      default: state_d = vha_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ft_d         = ft_q;
    hw_d         = hw_q;
    live_d       = live_q;
    cmd_d        = cmd_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    ver_d        = ver_q;
    emit         = 1'b0;
    out_res_d    = out_res_q;
    vmem_we_o    = 1'b0;
    vmem_waddr_o = '0;
    vmem_wdata_o = '0;
    vmem_re_o    = 1'b0;
    vmem_raddr_o = '0;
    smem_we_o    = 1'b0;
    smem_waddr_o = '0;
    smem_wdata_o = '0;
    smem_re_o    = 1'b0;
    smem_raddr_o = '0;

    unique case (state_q)
      vha_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d        = vha_pkg::cmd_e'(command_i);
          idx_d        = slot_index_i;
          ver_d        = slot_version_i;
          rem_d        = (32'(request_count_i) > 32'(MAX_BATCH)) ? RW'(MAX_BATCH)
                                                                 : RW'(request_count_i);
          vmem_re_o    = 1'b1;
          vmem_raddr_o = IW'(slot_index_i);
        end
      end
      vha_pkg::S_CREATE: begin
        if (have_free) begin
          smem_re_o    = 1'b1;
          smem_raddr_o = IW'(ft_q - 1'b1);
          ft_d         = ft_q - 1'b1;
        end else if (can_emit) begin
          emit = 1'b1;
          if (have_hw) begin
            vmem_we_o    = 1'b1;
            vmem_waddr_o = IW'(hw_q);
            vmem_wdata_o = {1'b1, VB'(0)};
            hw_d         = hw_q + 1'b1;
            live_d       = live_q + 1'b1;
            rem_d        = rem_q - 1'b1;
            out_res_d.index        = vha_pkg::IDX_W'(hw_q);
            out_res_d.version      = '0;
            out_res_d.status       = vha_pkg::STAT_OK;
            out_res_d.handle_valid = 1'b1;
            out_res_d.last         = last_one;
          end else begin
            out_res_d.index        = '0;
            out_res_d.version      = '0;
            out_res_d.status       = vha_pkg::STAT_FULL;
            out_res_d.handle_valid = 1'b0;
            out_res_d.last         = 1'b1;
          end
        end
      end
      vha_pkg::S_POP: begin
        if (can_emit) begin
          emit         = 1'b1;
          vmem_we_o    = 1'b1;
          vmem_waddr_o = pop_slot;
          vmem_wdata_o = {1'b1, pop_ver};
          live_d       = live_q + 1'b1;
          rem_d        = rem_q - 1'b1;
          out_res_d.index        = vha_pkg::IDX_W'(pop_slot);
          out_res_d.version      = vha_pkg::VER_W'(pop_ver);
          out_res_d.status       = vha_pkg::STAT_OK;
          out_res_d.handle_valid = 1'b1;
          out_res_d.last         = last_one;
        end
      end
      vha_pkg::S_LOOK: begin
        if (can_emit) begin
          emit                   = 1'b1;
          out_res_d.index        = idx_q;
          out_res_d.last         = 1'b1;
          out_res_d.version      = vha_pkg::VER_W'(stored_ver);
          out_res_d.status       = vha_pkg::STAT_STALE;
          out_res_d.handle_valid = 1'b0;
          case (cmd_q)
            vha_pkg::CMD_DESTROY: begin
              if (ok) begin
                vmem_we_o    = 1'b1;
                vmem_waddr_o = IW'(idx_q);
                vmem_wdata_o = {1'b0, new_ver};
                // freed slot goes on the stack with its new version
                if (32'(ft_q) < 32'(MAX_SLOTS)) begin
                  smem_we_o    = 1'b1;
                  smem_waddr_o = IW'(ft_q);
                  smem_wdata_o = {IW'(idx_q), new_ver};
                  ft_d         = ft_q + 1'b1;
                end
                if (live_q != '0) begin
                  live_d = live_q - 1'b1;
                end
                out_res_d.version      = vha_pkg::VER_W'(new_ver);
                out_res_d.status       = vha_pkg::STAT_OK;
                out_res_d.handle_valid = 1'b1;
              end
            end
            vha_pkg::CMD_CHECK: begin
              if (ok) begin
                out_res_d.status       = vha_pkg::STAT_OK;
                out_res_d.handle_valid = 1'b1;
              end
            end
            default: begin
              out_res_d.version = '0;
            end
          endcase
        end
      end
      default: ;
    endcase

    out_res_d.live_count = vha_pkg::LIVE_W'(live_d);
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vha_pkg::S_IDLE;
      ft_q        <= '0;
      hw_q        <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ft_q        <= ft_d;
      hw_q        <= hw_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rem_q     <= rem_d;
    idx_q     <= idx_d;
    ver_q     <= ver_d;
    out_res_q <= out_res_d;
  end

  assign in_stall_o  = (state_q != vha_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

FILE: sv/vha_chk.sv
`timescale 1ns / 1ps
module vha_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [vha_pkg::CMD_W-1:0]     command_i,
  input logic [vha_pkg::REQ_W-1:0]     request_count_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [vha_pkg::IDX_W-1:0]     out_index_o,
  input logic [vha_pkg::STATUS_W-1:0]  status_o,
  input logic                          handle_valid_o,
  input logic                          last_o
);

  // a held result keeps its valid, index and status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_index_o) && $stable(status_o))
    else $error("held result changed");

  // a transaction with work to do keeps the unit busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (command_i != vha_pkg::CMD_CREATE || request_count_i != '0) |=> in_stall_o)
    else $error("unit free straight after accepting work");

  // handle_valid goes with an ok status and with nothing else
  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (handle_valid_o == (status_o == vha_pkg::STAT_OK)))
    else $error("handle_valid disagrees with status");

  // out of space ends the request
  a_full_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == vha_pkg::STAT_FULL |-> last_o && out_index_o == '0)
    else $error("full result not final");

endmodule

bind versioned_handle_allocator_unit vha_chk u_vha_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .command_i       (command_i),
  .request_count_i (request_count_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_index_o     (out_index_o),
  .status_o        (status_o),
  .handle_valid_o  (handle_valid_o),
  .last_o          (last_o)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;

  // block configuration, default parameters of the unit
  localparam int unsigned NUM_SLOTS  = 1024;
  localparam int unsigned BATCH_MAX  = 64;
  // generous cycle budget for the whole run
  localparam int unsigned CYCLE_CAP  = 3000000;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int unsigned HOLD_LEN   = 300;
  // quiet cycles after the last result, lets any unexpected extra result show up
  localparam int unsigned TAIL_WAIT  = 20;

  // handle allocator predictor plus store of expected results
  class alloc_scoreboard;
    bit [vha_pkg::VER_W-1:0]  version_mem [NUM_SLOTS];
    bit                       slot_live   [NUM_SLOTS];
    bit [vha_pkg::IDX_W-1:0]  free_stack  [NUM_SLOTS];
    int unsigned              free_top;
    int unsigned              high_water;
    int unsigned              live_total;
    int unsigned              live_q [$];
    vha_pkg::result_t         expected_q [$];
    int unsigned              errors;

    function void push_result(bit [vha_pkg::IDX_W-1:0] idx, bit [vha_pkg::VER_W-1:0] ver,
                              vha_pkg::status_e st, bit ok, bit lst);
      vha_pkg::result_t r;
      r.index        = idx;
      r.version      = ver;
      r.status       = st;
      r.handle_valid = ok;
      r.live_count   = vha_pkg::LIVE_W'(live_total);
      r.last         = lst;
      expected_q     = {expected_q, r};
    endfunction

    // works out the results of one accepted transaction and moves the state on
    function void note_input(vha_pkg::cmd_e cmd, bit [vha_pkg::REQ_W-1:0] req,
                             bit [vha_pkg::IDX_W-1:0] idx, bit [vha_pkg::VER_W-1:0] ver);
      int unsigned n;
      int unsigned k;
      int unsigned slot;
      int unsigned i;
      bit          match;
      n     = (int'(req) > BATCH_MAX) ? BATCH_MAX : int'(req);
      match = slot_live[idx] && (version_mem[idx] == ver);
      case (cmd)
        vha_pkg::CMD_CREATE: begin
          for (k = 0; k < n; k++) begin
            if (free_top > 0) begin
              free_top--;
              slot = int'(free_stack[free_top]);
            end else if (high_water < NUM_SLOTS) begin
              slot = high_water;
              high_water++;
            end else begin
              // out of space, handles already given stay live
              push_result('0, '0, vha_pkg::STAT_FULL, 1'b0, 1'b1);
              return;
            end
            slot_live[slot] = 1'b1;
            live_total++;
            live_q = {live_q, slot};
            push_result(vha_pkg::IDX_W'(slot), version_mem[slot], vha_pkg::STAT_OK, 1'b1,
                        (k + 1) == n);
          end
        end
        vha_pkg::CMD_DESTROY: begin
          if (!match) begin
            push_result(idx, version_mem[idx], vha_pkg::STAT_STALE, 1'b0, 1'b1);
          end else begin
            version_mem[idx] = version_mem[idx] + vha_pkg::VER_W'(1);
            slot_live[idx]   = 1'b0;
            if (free_top < NUM_SLOTS) begin
              free_stack[free_top] = idx;
              free_top++;
            end
            if (live_total > 0) live_total--;
            for (i = 0; i < live_q.size(); i++) begin
              if (live_q[i] == int'(idx)) begin
                live_q.delete(i);
                break;
              end
            end
            push_result(idx, version_mem[idx], vha_pkg::STAT_OK, 1'b1, 1'b1);
          end
        end
        vha_pkg::CMD_CHECK: begin
          push_result(idx, version_mem[idx], match ? vha_pkg::STAT_OK : vha_pkg::STAT_STALE,
                      match, 1'b1);
        end
        default: begin
          push_result(idx, '0, vha_pkg::STAT_STALE, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(vha_pkg::result_t got);
      vha_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: idx %0d ver %0h st %0d hv %0b live %0d last %0b",
                   got.index, got.version, got.status, got.handle_valid,
                   got.live_count, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: exp idx %0d ver %0h st %0d hv %0b live %0d last %0b, ",
                    "got idx %0d ver %0h st %0d hv %0b live %0d last %0b"},
                   want.index, want.version, want.status, want.handle_valid,
                   want.live_count, want.last, got.index, got.version, got.status,
                   got.handle_valid, got.live_count, got.last);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [vha_pkg::CMD_W-1:0]     command_i;
  logic [vha_pkg::REQ_W-1:0]     request_count_i;
  logic [vha_pkg::IDX_W-1:0]     slot_index_i;
  logic [vha_pkg::VER_W-1:0]     slot_version_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [vha_pkg::IDX_W-1:0]     out_index_o;
  logic [vha_pkg::VER_W-1:0]     out_version_o;
  logic [vha_pkg::STATUS_W-1:0]  status_o;
  logic                          handle_valid_o;
  logic [vha_pkg::LIVE_W-1:0]    live_count_o;
  logic                          last_o;

  alloc_scoreboard  sb = new;
  vha_pkg::result_t got_result;

  // idling percentages, changed per phase by the stimulus process
  int unsigned idle_pct;
  int unsigned stall_pct;
  // long hold-off requests, handshake between stimulus and receiver processes
  int unsigned hold_asked;
  int unsigned hold_done;
  int unsigned hold_cycles;
  int unsigned cycle_count;
  int unsigned n_item;

  versioned_handle_allocator_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .request_count_i (request_count_i),
    .slot_index_i    (slot_index_i),
    .slot_version_i  (slot_version_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_index_o     (out_index_o),
    .out_version_o   (out_version_o),
    .status_o        (status_o),
    .handle_valid_o  (handle_valid_o),
    .live_count_o    (live_count_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls per phase, plus the odd long hold-off counted here
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_done != hold_asked) begin
        hold_done++;
        out_stall_i <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < HOLD_LEN) begin
          @(negedge clk_i);
          hold_cycles++;
        end
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // result monitor, sampled at the rising edge where a result is taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_result.index        = out_index_o;
      got_result.version      = out_version_o;
      got_result.status       = vha_pkg::status_e'(status_o);
      got_result.handle_valid = handle_valid_o;
      got_result.live_count   = live_count_o;
      got_result.last         = last_o;
      sb.check_result(got_result);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: done, errors");
    $finish;
  end

  // offers one transaction from a falling edge, returns at the falling edge after
  // acceptance; valid stays up into the next item unless a gap is drawn
  task automatic send_item(vha_pkg::cmd_e cmd, bit [vha_pkg::REQ_W-1:0] req,
                           bit [vha_pkg::IDX_W-1:0] idx, bit [vha_pkg::VER_W-1:0] ver);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    request_count_i <= req;
    slot_index_i    <= idx;
    slot_version_i  <= ver;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(cmd, req, idx, ver);
    @(negedge clk_i);
  endtask

  // sender pause until every outstanding result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // mostly well-formed traffic on live handles, some stale and malformed handles
  task automatic random_item();
    int unsigned              pick;
    int unsigned              sel;
    vha_pkg::cmd_e            cmd;
    bit [vha_pkg::REQ_W-1:0]  req;
    bit [vha_pkg::IDX_W-1:0]  idx;
    bit [vha_pkg::VER_W-1:0]  ver;
    // unused fields carry noise
    req  = vha_pkg::REQ_W'($urandom);
    idx  = vha_pkg::IDX_W'($urandom);
    ver  = vha_pkg::VER_W'($urandom);
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (pick < 40) begin
      cmd = vha_pkg::CMD_CREATE;
      if (sel < 70)      req = vha_pkg::REQ_W'($urandom_range(1, 4));
      else if (sel < 90) req = vha_pkg::REQ_W'($urandom_range(5, 32));
      else if (sel < 96) req = vha_pkg::REQ_W'($urandom_range(33, 64));
      else if (sel < 98) req = '0;
      else               req = vha_pkg::REQ_W'($urandom_range(65, 127));
    end else begin
      if (pick < 70)      cmd = vha_pkg::CMD_DESTROY;
      else if (pick < 95) cmd = vha_pkg::CMD_CHECK;
      else                cmd = vha_pkg::CMD_UNKNOWN;
      if (cmd != vha_pkg::CMD_UNKNOWN && sb.live_q.size() > 0 && sel < 75) begin
        idx = vha_pkg::IDX_W'(sb.live_q[$urandom_range(0, sb.live_q.size() - 1)]);
        ver = sb.version_mem[idx];
        // near miss on the version of a live handle
        if (sel >= 62) ver = ver ^ (vha_pkg::VER_W'(1) << $urandom_range(0, vha_pkg::VER_W - 1));
      end else if (cmd != vha_pkg::CMD_UNKNOWN && sb.high_water > 0 && sel < 90) begin
        // current version of any slot ever used, live or freed
        idx = vha_pkg::IDX_W'($urandom_range(0, sb.high_water - 1));
        ver = sb.version_mem[idx];
      end
    end
    send_item(cmd, req, idx, ver);
  endtask

  task automatic random_phase(int unsigned count);
    for (int unsigned j = 0; j < count; j++) random_item();
  endtask

  initial begin
    in_valid_i      = 1'b0;
    command_i       = vha_pkg::CMD_CREATE;
    request_count_i = '0;
    slot_index_i    = '0;
    slot_version_i  = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_asked      = 0;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, field extremes, each special case
    send_item(vha_pkg::CMD_CHECK,   7'd0,   10'd0,    16'h0000);  // check of a never-used slot
    send_item(vha_pkg::CMD_DESTROY, 7'd0,   10'd1023, 16'hffff);  // destroy of a never-used slot
    send_item(vha_pkg::CMD_CREATE,  7'd0,   10'd1023, 16'hffff);  // zero request, nothing back
    send_item(vha_pkg::CMD_CREATE,  7'd1,   10'd0,    16'h0000);
    send_item(vha_pkg::CMD_CHECK,   7'd0,   10'd0,    16'h0000);  // good handle
    send_item(vha_pkg::CMD_CHECK,   7'd0,   10'd0,    16'hffff);  // wrong version
    send_item(vha_pkg::CMD_DESTROY, 7'd0,   10'd0,    16'h0001);  // stale, version differs
    send_item(vha_pkg::CMD_CREATE,  7'd127, 10'd0,    16'h0000);  // oversize, cut to a batch
    send_item(vha_pkg::CMD_DESTROY, 7'd0,   10'd0,    16'h0000);
    send_item(vha_pkg::CMD_DESTROY, 7'd0,   10'd0,    16'h0000);  // destroy of a freed slot
    send_item(vha_pkg::CMD_CHECK,   7'd0,   10'd0,    16'h0001);  // right version, not live
    send_item(vha_pkg::CMD_DESTROY, 7'd0,   10'd5,    16'h0000);
    send_item(vha_pkg::CMD_DESTROY, 7'd0,   10'd9,    16'h0000);
    send_item(vha_pkg::CMD_CREATE,  7'd4,   10'd0,    16'h0000);  // pops the stack, then counter
    send_item(vha_pkg::CMD_UNKNOWN, 7'd127, 10'd1023, 16'hffff);
    send_item(vha_pkg::CMD_UNKNOWN, 7'd0,   10'd0,    16'h0000);
    send_item(vha_pkg::CMD_CHECK,   7'd0,   10'd9,    16'h0001);
    send_item(vha_pkg::CMD_CREATE,  7'd64,  10'd1023, 16'hffff);
    drain();

    // random traffic under the different idling patterns
    random_phase(90);
    idle_pct = 67;
    random_phase(90);
    idle_pct  = 0;
    stall_pct = 67;
    // long hold-off while the sender keeps offering
    send_item(vha_pkg::CMD_CREATE, 7'd32, 10'd0, 16'h0000);
    hold_asked++;
    random_phase(90);
    idle_pct  = 14;
    stall_pct = 14;
    random_phase(90);
    drain();

    // fill the store to the top, then run into the full case
    idle_pct  = 0;
    stall_pct = 0;
    n_item    = 0;
    while ((sb.free_top > 0 || sb.high_water < NUM_SLOTS) && n_item < 40) begin
      send_item(vha_pkg::CMD_CREATE, 7'd64, vha_pkg::IDX_W'($urandom),
                vha_pkg::VER_W'($urandom));
      n_item++;
    end
    send_item(vha_pkg::CMD_CREATE, 7'd3, 10'd0, 16'h0000);
    idle_pct  = 14;
    stall_pct = 14;
    for (int unsigned j = 0; j < 3; j++) begin
      if (sb.live_q.size() > 0) begin
        n_item = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
        send_item(vha_pkg::CMD_DESTROY, 7'd0, vha_pkg::IDX_W'(n_item),
                  sb.version_mem[n_item]);
      end
    end
    // three handles back from the stack, then the full marker
    send_item(vha_pkg::CMD_CREATE, 7'd5, 10'd0, 16'h0000);
    random_phase(30);

    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/vha_pkg.sv
sv/vha_ram.sv
sv/vha_ctrl.sv
sv/versioned_handle_allocator_unit.sv
sv/vha_chk.sv
verif/tb.sv
